FILE: hdl/trapezoid_poly_integrator_top_defines.svh
// Assertion macros shared by the trapezoid integrator RTL.
// Define ASSERT_OFF to compile the assertions out; no other dependencies.
`ifndef TRAPEZOID_POLY_INTEGRATOR_TOP_DEFINES_SVH
`define TRAPEZOID_POLY_INTEGRATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/tpi_pkg.sv
// Shared types and constants of the trapezoid integrator.
// Used by tpi_horner, tpi_trig and the top level; no dependencies.
package tpi_pkg;

  localparam int unsigned COEF_COUNT = 6;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_SIN   = 2'd1;
  localparam logic [1:0] MODE_COS   = 2'd2;

  localparam logic [2:0] REG_COEF_LAST  = 3'd5;
  localparam logic [2:0] REG_OUTER_MODE = 3'd6;
  localparam logic [2:0] REG_STEP_SHIFT = 3'd7;

  // Angle constants in Q16.16, gain in Q2.30.
  localparam logic signed [20:0] Q_PI      = 21'sd205887;
  localparam logic signed [20:0] Q_TWO_PI  = 21'sd411775;
  localparam logic signed [20:0] Q_HALF_PI = 21'sd102944;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // floor(2^40 / 411775) and 2^31 mod 411775 for the modulo reduction.
  localparam logic [21:0] RECIP_TWO_PI = 22'd2670175;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic signed [20:0] OFFSET_MOD = 21'sd77023;

  localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OUT_MIN = 48'sh8000_0000_0000;

  typedef logic signed [31:0] q16_t;
  typedef logic [COEF_COUNT-1:0][31:0] coef_arr_t;

  // Sideband that travels with every sample through the evaluator.
  typedef struct packed {
    logic signed [31:0] point;
    logic               first;
    logic               last;
    logic               sat;
  } smp_tag_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] a;
    case (idx)
      5'd0:  a = 34'sd843314856;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043836;
      5'd3:  a = 34'sd133525158;
      5'd4:  a = 34'sd67021686;
      5'd5:  a = 34'sd33543515;
      5'd6:  a = 34'sd16775850;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194282;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048575;
      5'd11: a = 34'sd524287;
      5'd12: a = 34'sd262143;
      5'd13: a = 34'sd131071;
      5'd14: a = 34'sd65535;
      5'd15: a = 34'sd32767;
      5'd16: a = 34'sd16383;
      5'd17: a = 34'sd8191;
      5'd18: a = 34'sd4095;
      5'd19: a = 34'sd2047;
      5'd20: a = 34'sd1023;
      5'd21: a = 34'sd511;
      5'd22: a = 34'sd255;
      5'd23: a = 34'sd127;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/tpi_horner.sv
// Pipelined Horner evaluator of the degree-5 polynomial, two stages per term.
// Depends on tpi_pkg.
module tpi_horner
  import tpi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  coef_arr_t coef,
  input  logic      in_valid,
  input  smp_tag_t  in_tag,
  output logic      out_valid,
  output smp_tag_t  out_tag,
  output q16_t      out_value
);

  localparam int unsigned STEPS = COEF_COUNT - 1;

  logic              acc_v_r [0:STEPS];
  smp_tag_t          acc_t_r [0:STEPS];
  q16_t              acc_r   [0:STEPS];
  logic              mul_v_r [0:STEPS-1];
  smp_tag_t          mul_t_r [0:STEPS-1];
  logic signed [63:0] mul_r  [0:STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r[0] <= 1'b0;
    end else begin
      acc_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    acc_t_r[0] <= in_tag;
    acc_r[0]   <= q16_t'(coef[0]);
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [48:0] sum;
    logic               clamp_hi;
    logic               clamp_lo;
    smp_tag_t           tag_nxt;

    always_comb begin
      sum = 49'($signed(mul_r[k][63:16])) + 49'($signed(coef[k+1]));
      clamp_hi = sum > 49'sh0_7FFF_FFFF;
      clamp_lo = sum < -49'sh0_8000_0000;
      tag_nxt = mul_t_r[k];
      tag_nxt.sat = mul_t_r[k].sat | clamp_hi | clamp_lo;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mul_v_r[k]   <= 1'b0;
        acc_v_r[k+1] <= 1'b0;
      end else begin
        mul_v_r[k]   <= acc_v_r[k];
        acc_v_r[k+1] <= mul_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      mul_t_r[k] <= acc_t_r[k];
      mul_r[k]   <= acc_r[k] * acc_t_r[k].point;
      acc_t_r[k+1] <= tag_nxt;
      if (clamp_hi) begin
        acc_r[k+1] <= 32'sh7FFF_FFFF;
      end else if (clamp_lo) begin
        acc_r[k+1] <= 32'sh8000_0000;
      end else begin
        acc_r[k+1] <= sum[31:0];
      end
    end
  end

  assign out_valid = acc_v_r[STEPS];
  assign out_tag   = acc_t_r[STEPS];
  assign out_value = acc_r[STEPS];

endmodule

FILE: hdl/tpi_trig.sv
// Range reduction and pipelined CORDIC for the sine and cosine modes.
// Depends on tpi_pkg; plain mode passes the polynomial value through.
module tpi_trig
  import tpi_pkg::*;
#(
  parameter int unsigned ITER = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         mode,
  input  logic               in_valid,
  input  smp_tag_t           in_tag,
  input  q16_t               in_value,
  output logic               out_valid,
  output smp_tag_t           out_tag,
  output logic signed [32:0] out_value
);

  localparam int unsigned NI = (ITER > 24) ? 24 : ITER;
  localparam int unsigned RED = 4;
  localparam int unsigned DEPTH = RED + NI;

  // Pass-through of valid, sideband and raw value across all stages.
  logic     v_r [0:DEPTH];
  smp_tag_t t_r [0:DEPTH];
  q16_t     p_r [0:DEPTH];

  assign v_r[0] = in_valid;
  assign t_r[0] = in_tag;
  assign p_r[0] = in_value;

  for (genvar s = 0; s < DEPTH; s++) begin : g_pass
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      t_r[s+1] <= t_r[s];
      p_r[s+1] <= p_r[s];
    end
  end

  // Reduction: u = v + 2^31, quotient by reciprocal, one correction.
  logic [31:0]        u0;
  logic [31:0]        u1_r, u2_r;
  logic [53:0]        qm1_r;
  logic [32:0]        qd2_r;
  logic [19:0]        rem, rem1;
  logic signed [20:0] r0, r1, r2;
  logic signed [20:0] r3_r;
  logic signed [20:0] rf;
  logic               neg;

  assign u0 = {~in_value[31], in_value[30:0]};

  always_comb begin
    rem  = 20'(u2_r - qd2_r[31:0]);
    rem1 = (rem >= 20'(Q_TWO_PI)) ? rem - 20'(Q_TWO_PI) : rem;
    r0   = $signed({1'b0, rem1}) - OFFSET_MOD;
    r1   = (r0 < 0) ? r0 + Q_TWO_PI : r0;
    r2   = (r1 > Q_PI) ? r1 - Q_TWO_PI : r1;
  end

  always_ff @(posedge clk) begin
    u1_r  <= u0;
    qm1_r <= u0 * RECIP_TWO_PI;
    u2_r  <= u1_r;
    qd2_r <= qm1_r[53:RECIP_SHIFT] * 19'(Q_TWO_PI);
    r3_r  <= r2;
  end

  always_comb begin
    neg = 1'b0;
    rf  = r3_r;
    if (r3_r > Q_HALF_PI) begin
      rf  = Q_PI - r3_r;
      neg = 1'b1;
    end else if (r3_r < -Q_HALF_PI) begin
      rf  = -Q_PI - r3_r;
      neg = 1'b1;
    end
  end

  logic signed [33:0] cx_r [0:NI];
  logic signed [33:0] cy_r [0:NI];
  logic signed [33:0] cz_r [0:NI];
  logic               cn_r [0:NI];

  always_ff @(posedge clk) begin
    cx_r[0] <= CORDIC_GAIN;
    cy_r[0] <= 34'sd0;
    cz_r[0] <= 34'(rf) <<< 14;
    cn_r[0] <= neg;
  end

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    logic signed [33:0] dx, dy, at;
    always_comb begin
      dx = cy_r[i] >>> i;
      dy = cx_r[i] >>> i;
      at = atan_q30(5'(i));
    end
    always_ff @(posedge clk) begin
      cn_r[i+1] <= cn_r[i];
      if (cz_r[i] >= 0) begin
        cx_r[i+1] <= cx_r[i] - dx;
        cy_r[i+1] <= cy_r[i] + dy;
        cz_r[i+1] <= cz_r[i] - at;
      end else begin
        cx_r[i+1] <= cx_r[i] + dx;
        cy_r[i+1] <= cy_r[i] - dy;
        cz_r[i+1] <= cz_r[i] + at;
      end
    end
  end

  logic signed [19:0] sin_v, cos_v;
  logic signed [32:0] res_nxt;
  logic signed [32:0] res_r;
  logic               ov_r;
  smp_tag_t           ot_r;

  always_comb begin
    sin_v = 20'(cy_r[NI] >>> 14);
    cos_v = 20'(cx_r[NI] >>> 14);
    case (mode)
      MODE_SIN: res_nxt = 33'(sin_v);
      MODE_COS: res_nxt = cn_r[NI] ? -33'(cos_v) : 33'(cos_v);
      default:  res_nxt = 33'(p_r[DEPTH]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v_r[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    ot_r  <= t_r[DEPTH];
    res_r <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_tag   = ot_r;
  assign out_value = res_r;

endmodule

FILE: hdl/trapezoid_poly_integrator_top.sv
// Top level of the trapezoid integrator: configuration registers, sample
// sequencer, slice accumulator and output register. Uses tpi_pkg,
// tpi_horner, tpi_trig and the assertion macros header.
//
// One interval transfer yields one integral transfer. After an interval is
// taken, the sequencer issues the 2^step_shift + 1 sample points, one per
// clock, into a fully pipelined evaluator (eleven Horner stages, four range
// reduction stages, one stage per CORDIC rotation and one select stage),
// then four slice stages form each trapezoid area and add it into the
// saturating accumulator. The next interval is taken as soon as the result
// has moved into the output register, even while that register still waits
// for its transfer. The reset step_shift is 16; step shifts above
// MAX_STEP_SHIFT are used as MAX_STEP_SHIFT, and outer mode 3 acts as the
// plain polynomial.
`include "trapezoid_poly_integrator_top_defines.svh"
module trapezoid_poly_integrator_top
  import tpi_pkg::*;
#(
  parameter int unsigned MAX_STEP_SHIFT = 20,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // lower_bound [31:0], upper_bound [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // integral_value [47:0]
  output logic        out_tuser   // overflow [0]
);

  localparam int unsigned CW = MAX_STEP_SHIFT + 1;
  localparam int unsigned PW = 33 + CW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FEED   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // Configuration registers.
  coef_arr_t  coef_r;
  logic [1:0] mode_r;
  logic [4:0] shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= '0;
      mode_r  <= MODE_PLAIN;
      shift_r <= 5'd16;
    end else if (cfg_wr_en) begin
      if (cfg_addr <= REG_COEF_LAST) begin
        coef_r[cfg_addr] <= cfg_wdata;
      end else if (cfg_addr == REG_OUTER_MODE) begin
        mode_r <= cfg_wdata[1:0];
      end else begin
        shift_r <= cfg_wdata[4:0];
      end
    end
  end

  // Sequencer: point i = lower + floor(d * i / 2^sh), with d * i kept as a
  // running sum so that no multiplier sits in the issue loop.
  logic [1:0]         state_r, state_nxt;
  logic signed [31:0] lower_r;
  logic signed [PW-1:0] diff_r, prod_r;
  logic [CW-1:0]      idx_r, cnt_r;
  logic [4:0]         sh_r;
  logic               accept;
  logic signed [PW-1:0] offs;
  logic               issue;
  smp_tag_t           issue_tag;
  logic               done_r;
  logic               load_out;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign issue     = (state_r == ST_FEED);
  assign load_out  = (state_r == ST_FINISH) && (!out_tvalid || out_tready);

  always_comb begin
    offs = prod_r >>> sh_r;
    issue_tag.point = lower_r + offs[31:0];
    issue_tag.first = (idx_r == '0);
    issue_tag.last  = (idx_r == cnt_r);
    issue_tag.sat   = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_FEED;
      ST_FEED:   if (idx_r == cnt_r) state_nxt = ST_WAIT;
      ST_WAIT:   if (done_r) state_nxt = ST_FINISH;
      ST_FINISH: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lower_r <= $signed(in_tdata[31:0]);
      diff_r  <= PW'($signed(in_tdata[63:32])) - PW'($signed(in_tdata[31:0]));
      prod_r  <= '0;
      idx_r   <= '0;
      if (shift_r > 5'(MAX_STEP_SHIFT)) begin
        sh_r  <= 5'(MAX_STEP_SHIFT);
        cnt_r <= CW'(1) << MAX_STEP_SHIFT;
      end else begin
        sh_r  <= shift_r;
        cnt_r <= CW'(1) << shift_r;
      end
    end else if (issue) begin
      prod_r <= prod_r + diff_r;
      idx_r  <= idx_r + CW'(1);
    end
  end

  // Evaluator pipeline.
  logic               h_valid;
  smp_tag_t           h_tag;
  q16_t               h_value;
  logic               e_valid;
  smp_tag_t           e_tag;
  logic signed [32:0] e_value;

  tpi_horner u_horner (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .in_valid  (issue),
    .in_tag    (issue_tag),
    .out_valid (h_valid),
    .out_tag   (h_tag),
    .out_value (h_value)
  );

  tpi_trig #(
    .ITER (CORDIC_ITERATIONS)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_valid  (h_valid),
    .in_tag    (h_tag),
    .in_value  (h_value),
    .out_valid (e_valid),
    .out_tag   (e_tag),
    .out_value (e_value)
  );

  // Slice stages. The area floor((fL + fR) * w / 2^17) is split into a high
  // and a low part of the width so that each product stays narrow.
  logic signed [32:0] prev_val_r;
  logic signed [31:0] prev_pt_r;
  logic               s1_v_r, s1_last_r;
  logic signed [33:0] s1_sum_r;
  logic signed [32:0] s1_w_r;
  logic               s2_v_r, s2_last_r;
  logic signed [49:0] s2_hi_r;
  logic signed [51:0] s2_lo_r;
  logic               s3_v_r, s3_last_r;
  logic signed [50:0] s3_term_r;
  logic signed [47:0] acc_r;
  logic               sat_r;
  logic signed [52:0] acc_sum;
  logic signed [15:0] w_hi;
  logic signed [17:0] w_lo;

  assign w_hi = 16'(s1_w_r >>> 17);
  assign w_lo = $signed({1'b0, s1_w_r[16:0]});
  assign acc_sum = 53'(acc_r) + 53'(s3_term_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= e_valid && !e_tag.first;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      done_r <= s3_v_r && s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e_valid) begin
      prev_val_r <= e_value;
      prev_pt_r  <= e_tag.point;
    end
    s1_last_r <= e_tag.last;
    s1_sum_r  <= 34'(prev_val_r) + 34'(e_value);
    s1_w_r    <= 33'(e_tag.point) - 33'(prev_pt_r);
    s2_last_r <= s1_last_r;
    s2_hi_r   <= s1_sum_r * w_hi;
    s2_lo_r   <= s1_sum_r * w_lo;
    s3_last_r <= s2_last_r;
    s3_term_r <= 51'(s2_hi_r) + 51'(s2_lo_r >>> 17);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (accept) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (e_valid && e_tag.sat) begin
        sat_r <= 1'b1;
      end
      if (s3_v_r) begin
        if (acc_sum > 53'(OUT_MAX)) begin
          acc_r <= OUT_MAX;
          sat_r <= 1'b1;
        end else if (acc_sum < 53'(OUT_MIN)) begin
          acc_r <= OUT_MIN;
          sat_r <= 1'b1;
        end else begin
          acc_r <= acc_sum[47:0];
        end
      end
    end
  end

  // Output register.
  logic        out_v_r;
  logic [47:0] out_d_r;
  logic        out_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_d_r <= acc_r;
      out_u_r <= sat_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

  `ASSERT_NEXT(a_accept_starts_feed, clk, rst_n, accept, state_r == ST_FEED)
  `ASSERT_IMPL(a_done_only_waiting, clk, rst_n, done_r, state_r == ST_WAIT)
  `ASSERT_IMPL(a_eval_not_idle, clk, rst_n, e_valid, state_r != ST_IDLE)
  `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, load_out, out_tvalid)

endmodule
